// File: rtl/core/pps_pkg.sv
`default_nettype none
package pps_pkg;

  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;
  localparam int TWO_PI_Q16  = 411775;
  localparam int KINV_Q30    = 652032874;
  localparam int CORDIC_STEPS = 16;

  // operand, angle and internal datapath widths of the cordic unit
  localparam int CIN_W  = 57;
  localparam int CANG_W = 20;
  localparam int CRES_W = 44;

  localparam logic [2:0] REG_LOOKAHEAD   = 3'd0;
  localparam logic [2:0] REG_WHEELBASE   = 3'd1;
  localparam logic [2:0] REG_MAX_STEER   = 3'd2;
  localparam logic [2:0] REG_TARGET_SPD  = 3'd3;
  localparam logic [2:0] REG_DRAG_GAIN   = 3'd4;
  localparam logic [2:0] REG_SPEED_GAIN  = 3'd5;
  localparam logic [2:0] REG_TORQUE_LIM  = 3'd6;
  localparam logic [2:0] REG_WP_COUNT    = 3'd7;

  typedef enum logic {
    CMODE_VECTOR = 1'b0,
    CMODE_ROTATE = 1'b1
  } cmode_t;

  typedef struct packed {
    logic                     go;
    cmode_t                   mode;
    logic signed [CIN_W-1:0]  x;
    logic signed [CIN_W-1:0]  y;
    logic signed [CANG_W-1:0] ang;
  } cor_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [CANG_W-1:0] ang;
    logic signed [CRES_W-1:0] val;
  } cor_rsp_t;

  function automatic logic signed [CANG_W-1:0] atan_step(input logic [3:0] i);
    logic signed [CANG_W-1:0] v;
    unique case (i)
      4'd0:  v = 20'sd51472;
      4'd1:  v = 20'sd30386;
      4'd2:  v = 20'sd16055;
      4'd3:  v = 20'sd8150;
      4'd4:  v = 20'sd4091;
      4'd5:  v = 20'sd2047;
      4'd6:  v = 20'sd1024;
      4'd7:  v = 20'sd512;
      4'd8:  v = 20'sd256;
      4'd9:  v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      4'd15: v = 20'sd2;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/pps_cordic.sv
`default_nettype none
module pps_cordic (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pps_pkg::cor_req_t req,
  output pps_pkg::cor_rsp_t      rsp
);
  import pps_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_NORM = 4'b0010,
    C_ITER = 4'b0100,
    C_POST = 4'b1000
  } cst_t;

  localparam logic signed [CANG_W-1:0] PI_A   = CANG_W'(PI_Q16);
  localparam logic signed [CANG_W-1:0] HPI_A  = CANG_W'(HALF_PI_Q16);
  localparam logic signed [CRES_W-1:0] KINV_C = CRES_W'(KINV_Q30);

  cst_t                     st_r, st_nxt;
  cmode_t                   mode_r;
  logic                     xneg_r, yneg_r, zero_r;
  logic [CIN_W-1:0]         ax_r, ay_r;
  logic signed [CRES_W-1:0] cx_r, cy_r;
  logic signed [CANG_W-1:0] z_r;
  logic [3:0]               it_r;
  logic                     done_r;
  logic signed [CANG_W-1:0] ang_r;
  logic signed [CRES_W-1:0] val_r;

  logic [CIN_W-1:0]         mx;
  logic signed [CRES_W-1:0] sx, sy;
  logic signed [CANG_W-1:0] tab, fold, zpost;

  always_comb begin
    mx    = (ax_r > ay_r) ? ax_r : ay_r;
    sx    = cx_r >>> it_r;
    sy    = cy_r >>> it_r;
    tab   = atan_step(it_r);
    if (req.ang > HPI_A) begin
      fold = PI_A - req.ang;
    end else if (req.ang < -HPI_A) begin
      fold = -PI_A - req.ang;
    end else begin
      fold = req.ang;
    end
    zpost = z_r;
    if (xneg_r) zpost = PI_A - zpost;
    if (yneg_r) zpost = -zpost;
    if (zero_r) zpost = '0;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      C_IDLE: if (req.go) st_nxt = (req.mode == CMODE_VECTOR) ? C_NORM : C_ITER;
      C_NORM: if (zero_r || (mx[CIN_W-1:41] == '0 && mx[40])) begin
        st_nxt = zero_r ? C_POST : C_ITER;
      end
      C_ITER: if (it_r == 4'(CORDIC_STEPS - 1)) st_nxt = C_POST;
      C_POST: st_nxt = C_IDLE;
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == C_POST);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      C_IDLE: begin
        it_r   <= '0;
        mode_r <= req.mode;
        xneg_r <= req.x[CIN_W-1];
        yneg_r <= req.y[CIN_W-1];
        zero_r <= (req.x == '0) && (req.y == '0);
        ax_r   <= req.x[CIN_W-1] ? CIN_W'(-req.x) : CIN_W'(req.x);
        ay_r   <= req.y[CIN_W-1] ? CIN_W'(-req.y) : CIN_W'(req.y);
        cx_r   <= KINV_C;
        cy_r   <= '0;
        z_r    <= (req.mode == CMODE_VECTOR) ? '0 : fold;
      end
      C_NORM: begin
        if (mx[CIN_W-1:41] != '0) begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
        end else if (!mx[40]) begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
        end else begin
          cx_r <= $signed(CRES_W'(ax_r));
          cy_r <= $signed(CRES_W'(ay_r));
        end
      end
      C_ITER: begin
        it_r <= it_r + 4'd1;
        if (mode_r == CMODE_VECTOR) begin
          if (cy_r >= 0) begin
            cx_r <= cx_r + sy;
            cy_r <= cy_r - sx;
            z_r  <= z_r + tab;
          end else begin
            cx_r <= cx_r - sy;
            cy_r <= cy_r + sx;
            z_r  <= z_r - tab;
          end
        end else begin
          if (z_r >= 0) begin
            cx_r <= cx_r - sy;
            cy_r <= cy_r + sx;
            z_r  <= z_r - tab;
          end else begin
            cx_r <= cx_r + sy;
            cy_r <= cy_r - sx;
            z_r  <= z_r + tab;
          end
        end
      end
      C_POST: begin
        ang_r <= zpost;
        val_r <= cy_r;
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.ang  = ang_r;
  assign rsp.val  = val_r;

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> st_r == C_IDLE) else $error("cordic started while busy");
  a_done_post: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(st_r == C_POST)) else $error("cordic done without finish");
  a_norm_mode: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == C_NORM |-> mode_r == CMODE_VECTOR) else $error("normalize in rotation");

endmodule
`default_nettype wire

// File: rtl/core/pure_pursuit_steering_unit.sv
// pure pursuit steering and speed controller
// input channel in_*: in_tuser is func (0 waypoint write, 1 control update),
//   in_tdata carries the waypoint and car fields of each beat
// result channel out_*: one beat per control update with steer and torque
// config port cfg_*: register index and data, written on cfg_we; the user
//   must write only while idle, as the block does not enforce it
// a waypoint write gives no result beat
// an update runs the start-index modulo and the table walk (n = waypoints
//   in use, one table word read per cycle), then a vectoring cordic run,
//   a rotation run and a second vectoring run; one item is in work at a time
// the result sits in an output register; in_tready comes back while it
//   waits, and a second update holds in its last step until the first
//   result beat is taken
// reset clears control state and loads the register defaults; the
//   waypoint table is not cleared and must be written before use
`default_nettype none
module pure_pursuit_steering_unit #(
  parameter int MAX_WAYPOINTS = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // wp_index, wp_x, wp_y, car_x, car_y, car_heading, car_speed, start_index
  input  wire logic [183:0]  in_tdata,
  // func
  input  wire logic          in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // steer_angle, drive_torque, zero pad
  output logic [39:0]        out_tdata,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [24:0]   cfg_wdata
);
  import pps_pkg::*;

  localparam int AW = $clog2(MAX_WAYPOINTS);
  localparam int NW = $clog2(MAX_WAYPOINTS + 1);

  localparam logic signed [21:0] PI22  = 22'(PI_Q16);
  localparam logic signed [21:0] TPI22 = 22'(TWO_PI_Q16);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MOD  = 7'b0000010,
    S_SRCH = 7'b0000100,
    S_ATN1 = 7'b0001000,
    S_SIN  = 7'b0010000,
    S_ATN2 = 7'b0100000,
    S_DONE = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;

  logic [24:0] la_r;
  logic [19:0] wb_r;
  logic [16:0] ms_r;
  logic [15:0] ts_r, dg_r, sg_r, tl_r;
  logic [10:0] wc_r;

  logic signed [31:0] cx_r, cy_r;
  logic signed [19:0] hd_r;
  logic [15:0]        sp_r;
  logic [9:0]         si_r;

  logic in_acc, wr_en;
  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && !in_tuser && (32'(in_tdata[9:0]) < 32'(MAX_WAYPOINTS));

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r <= 25'd327680;
      wb_r <= 20'd98304;
      ms_r <= 17'd22938;
      ts_r <= 16'd2560;
      dg_r <= 16'd256;
      sg_r <= 16'd12800;
      tl_r <= 16'd3200;
      wc_r <= 11'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOOKAHEAD:  la_r <= cfg_wdata;
        REG_WHEELBASE:  wb_r <= cfg_wdata[19:0];
        REG_MAX_STEER:  ms_r <= cfg_wdata[16:0];
        REG_TARGET_SPD: ts_r <= cfg_wdata[15:0];
        REG_DRAG_GAIN:  dg_r <= cfg_wdata[15:0];
        REG_SPEED_GAIN: sg_r <= cfg_wdata[15:0];
        REG_TORQUE_LIM: tl_r <= cfg_wdata[15:0];
        REG_WP_COUNT:   wc_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] n_c;
  always_comb begin
    if (wc_r == '0) begin
      n_c = NW'(1);
    end else if (32'(wc_r) > 32'(MAX_WAYPOINTS)) begin
      n_c = NW'(MAX_WAYPOINTS);
    end else begin
      n_c = NW'(wc_r);
    end
  end

  // waypoint table, y in the upper half
  logic [63:0]   mem [MAX_WAYPOINTS];
  logic [63:0]   q_r;
  logic          rd_en;
  logic [AW-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(in_tdata[9:0])] <= {in_tdata[73:42], in_tdata[41:10]};
    if (rd_en) q_r <= mem[idx_r];
  end

  // start index modulo count, one bit per cycle
  logic [NW-1:0] rem_r;
  logic [3:0]    bc_r;
  logic [NW:0]   rem_t;
  logic [NW-1:0] rem_n;
  always_comb begin
    rem_t = {rem_r, si_r[bc_r]};
    rem_n = (rem_t >= {1'b0, n_c}) ? NW'(rem_t - {1'b0, n_c}) : NW'(rem_t);
  end

  // walk pipeline: read, distance, squares, compare
  logic [NW-1:0] cnt_r, idx_inc;
  logic          issue, last_iss;
  logic          p0_v_r, p0_first_r, p0_last_r;
  logic          a_v_r, a_first_r, a_last_r, a_big_r;
  logic [24:0]   a_ax_r, a_ay_r;
  logic [31:0]   a_wx_r, a_wy_r;
  logic          b_v_r, b_first_r, b_last_r, b_big_r;
  logic [49:0]   b_sx_r, b_sy_r;
  logic [31:0]   b_wx_r, b_wy_r;
  logic [49:0]   la2_r;
  logic [31:0]   px_r, py_r;
  logic          far;

  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;

  assign issue    = (st_r == S_SRCH) && (cnt_r != n_c);
  assign last_iss = (cnt_r == n_c - NW'(1));
  assign rd_en    = issue;
  assign idx_inc  = NW'(idx_r) + NW'(1);

  always_comb begin
    dx  = 33'(signed'(q_r[31:0])) - 33'(cx_r);
    dy  = 33'(signed'(q_r[63:32])) - 33'(cy_r);
    adx = dx[32] ? 33'(-dx) : 33'(dx);
    ady = dy[32] ? 33'(-dy) : 33'(dy);
    far = b_big_r || ({1'b0, b_sx_r} + {1'b0, b_sy_r} >= {1'b0, la2_r});
  end

  always_ff @(posedge clk) begin
    la2_r     <= la_r * la_r;
    p0_first_r <= (cnt_r == '0);
    p0_last_r  <= last_iss;
    a_big_r   <= (adx[32:25] != '0) || (ady[32:25] != '0);
    a_ax_r    <= adx[24:0];
    a_ay_r    <= ady[24:0];
    a_wx_r    <= q_r[31:0];
    a_wy_r    <= q_r[63:32];
    a_first_r <= p0_first_r;
    a_last_r  <= p0_last_r;
    b_sx_r    <= a_ax_r * a_ax_r;
    b_sy_r    <= a_ay_r * a_ay_r;
    b_big_r   <= a_big_r;
    b_wx_r    <= a_wx_r;
    b_wy_r    <= a_wy_r;
    b_first_r <= a_first_r;
    b_last_r  <= a_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || st_r != S_SRCH) begin
      p0_v_r <= 1'b0;
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
    end else begin
      p0_v_r <= issue;
      a_v_r  <= p0_v_r;
      b_v_r  <= a_v_r;
    end
  end

  // torque products, refreshed every cycle
  logic [31:0]        tp1_r;
  logic signed [33:0] tp2_r;
  logic signed [34:0] tsum;
  logic [15:0]        torque;
  always_ff @(posedge clk) begin
    tp1_r <= dg_r * sp_r;
    tp2_r <= 34'($signed({1'b0, sg_r}) * ($signed({1'b0, ts_r}) - $signed({1'b0, sp_r})));
  end

  always_comb begin
    tsum = $signed({3'b0, tp1_r}) + 35'(tp2_r);
    if (tsum <= 0) begin
      torque = '0;
    end else if (tsum[34:12] > 23'(tl_r)) begin
      torque = tl_r;
    end else begin
      torque = tsum[27:12];
    end
  end

  // cordic sequencing
  cor_req_t cor_req;
  cor_rsp_t cor_rsp;
  logic     go_r, go_nxt;

  logic signed [21:0] err0, err1, err2;
  logic signed [19:0] err_r;
  logic signed [56:0] num_r;
  logic signed [52:0] prod;
  logic signed [19:0] msx, steer;
  logic signed [19:0] steer_r;

  always_comb begin
    err0 = 22'(cor_rsp.ang) - 22'(hd_r);
    if (err0 > PI22) err1 = err0 - TPI22;
    else if (err0 < -PI22) err1 = err0 + TPI22;
    else err1 = err0;
    if (err1 > PI22) err2 = err1 - TPI22;
    else if (err1 < -PI22) err2 = err1 + TPI22;
    else err2 = err1;
    prod  = $signed({1'b0, wb_r}) * $signed(cor_rsp.val[31:0]);
    msx   = $signed({3'b0, ms_r});
    steer = cor_rsp.ang;
    if (steer > msx) steer = msx;
    if (steer < -msx) steer = -msx;
  end

  always_comb begin
    cor_req.go   = go_r;
    cor_req.mode = (st_r == S_SIN) ? CMODE_ROTATE : CMODE_VECTOR;
    cor_req.ang  = err_r;
    if (st_r == S_ATN2) begin
      cor_req.y = num_r;
      cor_req.x = $signed({2'b0, la_r, 30'b0});
    end else begin
      cor_req.y = 57'($signed(py_r)) - 57'(cy_r);
      cor_req.x = 57'($signed(px_r)) - 57'(cx_r);
    end
  end

  pps_cordic u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (cor_req),
    .rsp  (cor_rsp)
  );

  // main sequencer
  logic out_free;
  assign out_free = !out_tvalid || out_tready;

  always_comb begin
    st_nxt = st_r;
    go_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_acc && in_tuser) st_nxt = S_MOD;
      S_MOD:  if (bc_r == '0) st_nxt = S_SRCH;
      S_SRCH: if (b_v_r && (far || b_last_r)) begin
        st_nxt = S_ATN1;
        go_nxt = 1'b1;
      end
      S_ATN1: if (cor_rsp.done) begin
        st_nxt = S_SIN;
        go_nxt = 1'b1;
      end
      S_SIN: if (cor_rsp.done) begin
        st_nxt = S_ATN2;
        go_nxt = 1'b1;
      end
      S_ATN2: if (cor_rsp.done) st_nxt = S_DONE;
      S_DONE: if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      go_r       <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      go_r <= go_nxt;
      if (st_r == S_DONE && out_free) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cx_r  <= in_tdata[105:74];
      cy_r  <= in_tdata[137:106];
      hd_r  <= in_tdata[157:138];
      sp_r  <= in_tdata[173:158];
      si_r  <= in_tdata[183:174];
      rem_r <= '0;
      bc_r  <= 4'd9;
    end
    if (st_r == S_MOD) begin
      rem_r <= rem_n;
      bc_r  <= bc_r - 4'd1;
      if (bc_r == '0) begin
        idx_r <= AW'(rem_n);
        cnt_r <= '0;
      end
    end
    if (issue) begin
      cnt_r <= cnt_r + NW'(1);
      idx_r <= (idx_inc >= n_c) ? '0 : AW'(idx_inc);
    end
    if (st_r == S_SRCH && b_v_r && (b_first_r || far)) begin
      px_r <= b_wx_r;
      py_r <= b_wy_r;
    end
    if (st_r == S_ATN1 && cor_rsp.done) err_r <= err2[19:0];
    if (st_r == S_SIN && cor_rsp.done) num_r <= 57'(prod) <<< 1;
    if (st_r == S_ATN2 && cor_rsp.done) steer_r <= steer;
    if (st_r == S_DONE && out_free) begin
      out_tdata <= {6'b0, torque, steer_r[17:0]};
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_SRCH |-> NW'(idx_r) < n_c) else $error("walk index beyond count");
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cor_rsp.done |-> (st_r == S_ATN1 || st_r == S_SIN || st_r == S_ATN2))
    else $error("cordic result outside a run");
  a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser |=> !in_tready) else $error("update did not start");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(st_r == S_DONE)) else $error("result without update");

endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pps_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int FILL_SLOTS = 40;
  localparam longint ANGLE_STEP [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2};

  typedef enum bit {OP_WP_WRITE = 1'b0, OP_UPDATE = 1'b1} op_t;

  typedef struct {
    op_t       op;
    bit [9:0]  wp_index;
    bit [31:0] wp_x;
    bit [31:0] wp_y;
    bit [31:0] car_x;
    bit [31:0] car_y;
    bit [19:0] heading;
    bit [15:0] speed;
    bit [9:0]  start;
  } beat_t;

  typedef struct {
    bit [17:0] steer;
    bit [15:0] torque;
  } cmd_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [183:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [24:0]  cfg_wdata;

  pure_pursuit_steering_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  beat_t  pending_q[$];
  cmd_t   cmd_q[$];
  beat_t  cur_beat;
  bit     in_beat;
  bit     out_beat;
  int     send_gap;
  int     recv_stall;
  bit     steady;
  int     errors;

  bit [31:0] wpx_shadow [TABLE_DEPTH];
  bit [31:0] wpy_shadow [TABLE_DEPTH];
  longint lookahead, wheelbase, max_steer, target_speed, drag_gain, speed_gain, torque_lim;
  longint wp_count;
  longint base_x, base_y;

  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  function automatic longint cordic_angle(longint y, longint x);
    longint unsigned ax, ay, mx;
    longint cx, cy, z, nx;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    z = 0;
    if (ax == 0 && ay == 0) return 0;
    mx = (ax > ay) ? ax : ay;
    while (mx >= (64'd1 << 41)) begin
      ax >>= 1; ay >>= 1; mx >>= 1;
    end
    while (mx < (64'd1 << 40)) begin
      ax <<= 1; ay <<= 1; mx <<= 1;
    end
    cx = ax;
    cy = ay;
    for (int i = 0; i < 16; i++) begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += ANGLE_STEP[i];
      end else begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= ANGLE_STEP[i];
      end
      cx = nx;
    end
    if (x < 0) z = PI_Q16 - z;
    if (y < 0) z = -z;
    return z;
  endfunction

  function automatic longint cordic_sine(longint a);
    longint cx, cy, nx;
    cx = KINV_Q30;
    cy = 0;
    if (a > HALF_PI_Q16) a = PI_Q16 - a;
    else if (a < -HALF_PI_Q16) a = -PI_Q16 - a;
    for (int i = 0; i < 16; i++) begin
      if (a >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        a -= ANGLE_STEP[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        a += ANGLE_STEP[i];
      end
      cx = nx;
    end
    return cy;
  endfunction

  function automatic cmd_t pursuit_command(beat_t b);
    cmd_t c;
    longint n, st, idx, cx, cy, px, py, wx, wy, dx, dy, err, num, den, steer, spd, sum, tq;
    longint unsigned ax, ay, la2;
    bit far;
    n = (wp_count == 0) ? 1 : (wp_count > TABLE_DEPTH ? TABLE_DEPTH : wp_count);
    st = longint'(b.start) % n;
    cx = longint'(signed'(b.car_x));
    cy = longint'(signed'(b.car_y));
    la2 = lookahead * lookahead;
    px = longint'(signed'(wpx_shadow[st]));
    py = longint'(signed'(wpy_shadow[st]));
    idx = st;
    for (longint i = 0; i < n; i++) begin
      wx = longint'(signed'(wpx_shadow[idx]));
      wy = longint'(signed'(wpy_shadow[idx]));
      dx = wx - cx;
      dy = wy - cy;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax >= (64'd1 << 25) || ay >= (64'd1 << 25)) far = 1'b1;
      else far = (ax * ax + ay * ay) >= la2;
      if (far) begin
        px = wx;
        py = wy;
        break;
      end
      idx++;
      if (idx >= n) idx = 0;
    end
    err = cordic_angle(py - cy, px - cx) - longint'(signed'(b.heading));
    while (err > PI_Q16) err -= TWO_PI_Q16;
    while (err < -PI_Q16) err += TWO_PI_Q16;
    num = 2 * wheelbase * cordic_sine(err);
    den = lookahead << 30;
    steer = cordic_angle(num, den);
    if (steer > max_steer) steer = max_steer;
    if (steer < -max_steer) steer = -max_steer;
    spd = b.speed;
    sum = drag_gain * spd + speed_gain * (target_speed - spd);
    tq = (sum <= 0) ? 0 : (sum >> 12);
    if (tq > torque_lim) tq = torque_lim;
    c.steer = steer[17:0];
    c.torque = tq[15:0];
    return c;
  endfunction

  // sender
  always @(negedge clk) begin
    bit busy;
    beat_t b;
    busy = in_tvalid && !in_beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!busy) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        b = pending_q.pop_front();
        cur_beat <= b;
        in_tuser <= b.op;
        in_tdata <= {b.start, b.speed, b.heading, b.car_y, b.car_x, b.wp_y, b.wp_x, b.wp_index};
        in_tvalid <= 1'b1;
        send_gap <= steady ? 0 : $urandom_range(0, 15);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    int s;
    s = recv_stall;
    if (out_beat) s = steady ? 0 : $urandom_range(0, 15);
    else if (s > 0) s = s - 1;
    recv_stall <= s;
    out_tready <= rst_n && (s == 0);
  end

  // predict on input beats, check result beats
  always @(posedge clk) begin
    cmd_t want;
    in_beat <= in_tvalid && in_tready;
    out_beat <= out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      if (cur_beat.op == OP_WP_WRITE) begin
        wpx_shadow[cur_beat.wp_index] = cur_beat.wp_x;
        wpy_shadow[cur_beat.wp_index] = cur_beat.wp_y;
      end else begin
        cmd_q.push_back(pursuit_command(cur_beat));
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (cmd_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        want = cmd_q.pop_front();
        if (out_tdata[17:0] !== want.steer || out_tdata[33:18] !== want.torque) begin
          errors++;
          if (errors <= 10)
            $display("mismatch steer exp %h got %h, torque exp %h got %h",
                     want.steer, out_tdata[17:0], want.torque, out_tdata[33:18]);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, longint val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[24:0];
    case (idx)
      REG_LOOKAHEAD:  lookahead = val & 64'h1FFFFFF;
      REG_WHEELBASE:  wheelbase = val & 64'hFFFFF;
      REG_MAX_STEER:  max_steer = val & 64'h1FFFF;
      REG_TARGET_SPD: target_speed = val & 64'hFFFF;
      REG_DRAG_GAIN:  drag_gain = val & 64'hFFFF;
      REG_SPEED_GAIN: speed_gain = val & 64'hFFFF;
      REG_TORQUE_LIM: torque_lim = val & 64'hFFFF;
      REG_WP_COUNT:   wp_count = val & 64'h7FF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_tvalid || cmd_q.size() > 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  function automatic bit [31:0] near_coord(longint b);
    longint v;
    if ($urandom_range(0, 9) == 0) return $urandom;
    v = b + $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
    return v[31:0];
  endfunction

  function automatic bit [31:0] close_coord(longint b);
    longint v;
    v = b + $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
    return v[31:0];
  endfunction

  function automatic beat_t wp_beat(bit [9:0] slot, bit [31:0] x, bit [31:0] y);
    beat_t b;
    b.op = OP_WP_WRITE;
    b.wp_index = slot;
    b.wp_x = x;
    b.wp_y = y;
    b.car_x = $urandom;
    b.car_y = $urandom;
    b.heading = $urandom;
    b.speed = $urandom;
    b.start = $urandom;
    return b;
  endfunction

  function automatic beat_t upd_beat(bit [31:0] x, bit [31:0] y, bit [19:0] hd, bit [15:0] sp,
                                     bit [9:0] st);
    beat_t b;
    b.op = OP_UPDATE;
    b.wp_index = $urandom;
    b.wp_x = $urandom;
    b.wp_y = $urandom;
    b.car_x = x;
    b.car_y = y;
    b.heading = hd;
    b.speed = sp;
    b.start = st;
    return b;
  endfunction

  function automatic bit [19:0] rand_heading();
    int h;
    if ($urandom_range(0, 7) == 0) return $urandom;
    h = $urandom_range(0, 2 * TWO_PI_Q16) - TWO_PI_Q16;
    return h[19:0];
  endfunction

  initial begin
    longint v;
    bit long_walk;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_gap = 0;
    recv_stall = 0;
    steady = 1'b0;
    errors = 0;
    lookahead = 327680; wheelbase = 98304; max_steer = 22938; target_speed = 2560;
    drag_gain = 256; speed_gain = 12800; torque_lim = 3200; wp_count = 1;
    base_x = $signed($urandom_range(0, 2 ** 29)) - 2 ** 28;
    base_y = $signed($urandom_range(0, 2 ** 29)) - 2 ** 28;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset defaults, single waypoint, field extremes
    pending_q.push_back(wp_beat(10'd0, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_q.push_back(upd_beat(32'h8000_0000, 32'h7FFF_FFFF, 20'h80000, 16'd0, 10'd1023));
    pending_q.push_back(upd_beat(32'h7FFF_FFFF, 32'h8000_0000, 20'h7FFFF, 16'hFFFF, 10'd0));
    pending_q.push_back(upd_beat(32'h7FFF_FFFF, 32'h8000_0000, 20'd411775, 16'd2560, 10'd5));
    for (int i = 1; i < 8; i++)
      pending_q.push_back(wp_beat(i[9:0], near_coord(base_x), near_coord(base_y)));
    drain();

    // zero lookahead, widest clamp, count too large for the written part avoided
    write_reg(REG_WP_COUNT, 8);
    write_reg(REG_LOOKAHEAD, 0);
    write_reg(REG_MAX_STEER, 102944);
    write_reg(REG_WHEELBASE, 655360);
    pending_q.push_back(upd_beat(base_x[31:0], base_y[31:0], 20'd0, 16'd100, 10'd1023));
    pending_q.push_back(upd_beat(base_x[31:0], base_y[31:0], -20'sd411775, 16'd0, 10'd9));
    pending_q.push_back(upd_beat(near_coord(base_x), near_coord(base_y), 20'd205887,
                                 16'd65535, 10'd3));
    drain();
    write_reg(REG_WP_COUNT, 0);
    write_reg(REG_LOOKAHEAD, 16777216);
    write_reg(REG_MAX_STEER, 0);
    write_reg(REG_TARGET_SPD, 65535);
    write_reg(REG_DRAG_GAIN, 65535);
    write_reg(REG_SPEED_GAIN, 65535);
    write_reg(REG_TORQUE_LIM, 65535);
    pending_q.push_back(upd_beat(near_coord(base_x), near_coord(base_y), 20'd0, 16'd0, 10'd700));
    pending_q.push_back(upd_beat(near_coord(base_x), near_coord(base_y), 20'd0, 16'hFFFF,
                                 10'd1));
    drain();

    // fill the low slots; long counts start there and stop at a far sentinel
    steady = 1'b1;
    for (int i = 0; i < FILL_SLOTS; i++)
      pending_q.push_back(wp_beat(i[9:0], near_coord(base_x), near_coord(base_y)));
    drain();
    steady = 1'b0;

    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_LOOKAHEAD, (ph == 1) ? 65536 : (ph == 2) ? 16777216 :
                $urandom_range(65536, 4194304));
      write_reg(REG_WHEELBASE, (ph == 1) ? 6554 : (ph == 2) ? 655360 :
                $urandom_range(6554, 655360));
      write_reg(REG_MAX_STEER, (ph == 1) ? 0 : (ph == 2) ? 102944 : $urandom_range(0, 102944));
      write_reg(REG_TARGET_SPD, (ph == 1) ? 0 : (ph == 2) ? 65535 : $urandom_range(0, 65535));
      write_reg(REG_DRAG_GAIN, (ph == 1) ? 0 : (ph == 2) ? 65535 : $urandom_range(0, 65535));
      write_reg(REG_SPEED_GAIN, (ph == 1) ? 0 : (ph == 2) ? 65535 : $urandom_range(0, 65535));
      write_reg(REG_TORQUE_LIM, (ph == 1) ? 0 : (ph == 2) ? 65535 : $urandom_range(0, 65535));
      v = (ph == 3) ? 1024 : (ph == 4) ? 2047 : (ph == 1) ? 1 : $urandom_range(1, 24);
      write_reg(REG_WP_COUNT, v);
      steady = (ph == 5);
      long_walk = (ph == 3) || (ph == 4);
      if (long_walk)
        pending_q.push_back(wp_beat(10'(FILL_SLOTS), 32'(base_x + 2 ** 26),
                                    32'(base_y + 2 ** 26)));
      for (int k = 0; k < 25; k++) begin
        if ($urandom_range(0, 3) == 0)
          pending_q.push_back(wp_beat(long_walk ? 10'($urandom_range(0, FILL_SLOTS - 1)) :
                                      10'($urandom), near_coord(base_x), near_coord(base_y)));
        else if (long_walk)
          pending_q.push_back(upd_beat(close_coord(base_x), close_coord(base_y), rand_heading(),
                                       $urandom, 10'($urandom_range(0, FILL_SLOTS))));
        else
          pending_q.push_back(upd_beat(near_coord(base_x), near_coord(base_y), rand_heading(),
                                       $urandom, $urandom));
      end
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
